// File: design/gcor_pkg.sv
// ----------------------------------------------------------------------------
// gcor_pkg
// Shared types and constants for the greedy correlation outlier removal core.
// ----------------------------------------------------------------------------
package gcor_pkg;

    localparam int ROUNDS_W       = 7;
    localparam int VAL_W          = 16;
    localparam int INDEX_W        = 10;
    localparam int SCORE_W        = 16;
    localparam int SEARCH_BITS    = 16;
    localparam int FRAC_SHIFT     = 30;
    localparam int DEF_MAX_NODES  = 1024;
    localparam int DEF_MAX_ROUNDS = 64;

    typedef struct packed {
        logic signed [VAL_W-1:0] a_first;
        logic signed [VAL_W-1:0] a_second;
        logic signed [VAL_W-1:0] a_third;
        logic signed [VAL_W-1:0] b_first;
        logic signed [VAL_W-1:0] b_second;
        logic signed [VAL_W-1:0] b_third;
        logic                    last_node;
    } node_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] a_first;
        logic signed [VAL_W-1:0] a_second;
        logic signed [VAL_W-1:0] a_third;
        logic signed [VAL_W-1:0] b_first;
        logic signed [VAL_W-1:0] b_second;
        logic signed [VAL_W-1:0] b_third;
    } node_vals_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        removed_index;
        logic                      removal_valid;
        logic signed [SCORE_W-1:0] best_score;
        logic                      last_round;
    } result_item_t;

    typedef struct packed {
        logic                      done;
        logic                      defined;
        logic signed [SCORE_W-1:0] score;
    } score_res_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_SCAN_RD,
        ST_SCAN_PROD,
        ST_SCAN_SUB,
        ST_SCAN_START,
        ST_SCAN_WAIT,
        ST_EMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL_GO,
        SC_MUL_WAIT,
        SC_COMB,
        SC_SRCH_INIT,
        SC_SEARCH,
        SC_FIN
    } score_state_t;

endpackage

// File: design/gcor_mul.sv
// ----------------------------------------------------------------------------
// gcor_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gcor_mul
    import gcor_pkg::*;
#(
    parameter int W = 57
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [W-1:0]     x,
    input  logic [W-1:0]     y,
    output logic             done,
    output logic [2*W-1:0]   prod
);

    localparam int CNT_W = $clog2(W);

    logic [2*W-1:0] acc_reg, acc_next;
    logic [2*W-1:0] mc_reg, mc_next;
    logic [W-1:0]   mp_reg, mp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = (2*W)'(x);
            mp_next   = y;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand for a set bit, then advance
            if (mp_reg[0])
                acc_next = acc_reg + mc_reg;
            mc_next  = mc_reg << 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: design/gcor_score.sv
// ----------------------------------------------------------------------------
// gcor_score
// Leave-one-out Pearson score: exact spreads and covariance through a shared
// serial multiplier, then a bitwise root search for the Q1.15 magnitude.
// ----------------------------------------------------------------------------
module gcor_score
    import gcor_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [$clog2(MAX_NODES+1)+1:0]           n,
    input  logic signed [$clog2(MAX_NODES+1)+17:0]   sa,
    input  logic signed [$clog2(MAX_NODES+1)+17:0]   sb,
    input  logic [$clog2(MAX_NODES+1)+32:0]          saa,
    input  logic [$clog2(MAX_NODES+1)+32:0]          sbb,
    input  logic signed [$clog2(MAX_NODES+1)+32:0]   sab,
    output score_res_t                               res
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int SW = CW + 18;
    localparam int QW = CW + 33;
    localparam int VW = 2 * CW + 35;
    localparam int PW = 2 * VW;
    localparam int RW = PW + 34;

    localparam logic [2:0] STEP_NSAA = 3'd0;
    localparam logic [2:0] STEP_SASA = 3'd1;
    localparam logic [2:0] STEP_NSBB = 3'd2;
    localparam logic [2:0] STEP_SBSB = 3'd3;
    localparam logic [2:0] STEP_NSAB = 3'd4;
    localparam logic [2:0] STEP_SASB = 3'd5;
    localparam logic [2:0] STEP_VAVB = 3'd6;
    localparam logic [2:0] STEP_CC   = 3'd7;

    score_state_t state_reg, state_next;
    logic [2:0]   step_reg;
    logic [PW-1:0] prod_reg [8];
    logic [VW-1:0] va_reg, vb_reg, cmag_reg;
    logic          negc_reg, def_reg;
    logic [RW-1:0] a_reg, b_reg, q2_reg, r_reg;
    logic [SEARCH_BITS-1:0] q_reg;
    logic [3:0]    k_reg;

    logic [SW-1:0] sa_mag, sb_mag;
    logic [QW-1:0] sab_mag;
    logic [VW-1:0] op_x, op_y;
    logic          mul_start, mul_done;
    logic [PW-1:0] mul_prod;
    logic signed [PW+1:0] t1s, t2s, c_val;
    logic [PW+1:0] c_abs;
    logic [RW-1:0] trial;
    logic [SCORE_W-1:0] q_sat;

    assign sa_mag  = sa[SW-1] ? SW'(-sa) : SW'(sa);
    assign sb_mag  = sb[SW-1] ? SW'(-sb) : SW'(sb);
    assign sab_mag = sab[QW-1] ? QW'(-sab) : QW'(sab);

    always_comb
    begin
        case (step_reg)
            STEP_NSAA: begin op_x = VW'(n);       op_y = VW'(saa);     end
            STEP_SASA: begin op_x = VW'(sa_mag);  op_y = VW'(sa_mag);  end
            STEP_NSBB: begin op_x = VW'(n);       op_y = VW'(sbb);     end
            STEP_SBSB: begin op_x = VW'(sb_mag);  op_y = VW'(sb_mag);  end
            STEP_NSAB: begin op_x = VW'(n);       op_y = VW'(sab_mag); end
            STEP_SASB: begin op_x = VW'(sa_mag);  op_y = VW'(sb_mag);  end
            STEP_VAVB: begin op_x = va_reg;       op_y = vb_reg;       end
            STEP_CC:   begin op_x = cmag_reg;     op_y = cmag_reg;     end
            default:   begin op_x = '0;           op_y = '0;           end
        endcase
    end

    gcor_mul #(.W(VW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (op_x),
        .y     (op_y),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // covariance with signs of n*Sab and Sa*Sb restored
    always_comb
    begin
        t1s   = sab[QW-1] ? -$signed({2'b00, prod_reg[STEP_NSAB]})
                          :  $signed({2'b00, prod_reg[STEP_NSAB]});
        t2s   = (sa[SW-1] ^ sb[SW-1]) ? -$signed({2'b00, prod_reg[STEP_SASB]})
                                      :  $signed({2'b00, prod_reg[STEP_SASB]});
        c_val = t1s - t2s;
        c_abs = c_val[PW+1] ? (PW+2)'(-c_val) : (PW+2)'(c_val);
    end

    assign trial = q2_reg + b_reg + a_reg;
    assign q_sat = (q_reg > SEARCH_BITS'(32767)) ? SCORE_W'(32767) : SCORE_W'(q_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE:      if (start) state_next = SC_MUL_GO;
            SC_MUL_GO:    state_next = SC_MUL_WAIT;
            SC_MUL_WAIT:
                if (mul_done)
                begin
                    if (step_reg == STEP_SASB)
                        state_next = SC_COMB;
                    else if (step_reg == STEP_CC)
                        state_next = SC_SRCH_INIT;
                    else
                        state_next = SC_MUL_GO;
                end
            SC_COMB:      state_next = SC_MUL_GO;
            SC_SRCH_INIT: state_next = SC_SEARCH;
            SC_SEARCH:    if (k_reg == 4'd0) state_next = SC_FIN;
            SC_FIN:       state_next = SC_IDLE;
            default:      state_next = SC_IDLE;
        endcase
    end

    always_comb
    begin
        mul_start   = (state_reg == SC_MUL_GO);
        res.done    = (state_reg == SC_FIN);
        res.defined = def_reg;
        res.score   = negc_reg ? SCORE_W'(SEARCH_BITS'(0) - q_reg) : q_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            step_reg  <= STEP_NSAA;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SC_IDLE && start)
                step_reg <= STEP_NSAA;
            else if (state_reg == SC_MUL_WAIT && mul_done && step_reg != STEP_SASB
                     && step_reg != STEP_CC)
                step_reg <= step_reg + 3'd1;
            else if (state_reg == SC_COMB)
                step_reg <= STEP_VAVB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SC_MUL_WAIT && mul_done)
            prod_reg[step_reg] <= mul_prod;
        if (state_reg == SC_COMB)
        begin
            va_reg   <= VW'(prod_reg[STEP_NSAA] - prod_reg[STEP_SASA]);
            vb_reg   <= VW'(prod_reg[STEP_NSBB] - prod_reg[STEP_SBSB]);
            def_reg  <= (prod_reg[STEP_NSAA] > prod_reg[STEP_SASA]) &&
                        (prod_reg[STEP_NSBB] > prod_reg[STEP_SBSB]);
            cmag_reg <= VW'(c_abs);
            negc_reg <= c_val[PW+1];
        end
        if (state_reg == SC_SRCH_INIT)
        begin
            a_reg  <= RW'(prod_reg[STEP_VAVB]) << FRAC_SHIFT;
            r_reg  <= RW'(prod_reg[STEP_CC]) << FRAC_SHIFT;
            b_reg  <= '0;
            q2_reg <= '0;
            q_reg  <= '0;
            k_reg  <= 4'(SEARCH_BITS - 1);
        end
        if (state_reg == SC_SEARCH)
        begin
            // keep the bit when (q + 2^k)^2 * P still fits under C^2 * 2^30
            if (trial <= r_reg)
            begin
                q2_reg <= trial;
                b_reg  <= (b_reg >> 1) + a_reg;
                q_reg  <= q_reg | (SEARCH_BITS'(1) << k_reg);
            end
            else
                b_reg  <= b_reg >> 1;
            a_reg <= a_reg >> 2;
            k_reg <= k_reg - 4'd1;
        end
    end

endmodule

// File: design/greedy_correlation_outlier_removal_core.sv
// ----------------------------------------------------------------------------
// greedy_correlation_outlier_removal_core
// Loads nodes into a node memory, then per round drops the node whose removal
// maximizes the Pearson correlation of a against b over the remaining nodes.
// ----------------------------------------------------------------------------
// Load: one node per cycle in ST_LOAD, written straight into node memory.
// Round: a sum pass over the stored nodes, then a scan that reads each node
//   (SCAN_RD, SCAN_PROD, SCAN_SUB) and scores each included one in the score
//   unit's serial multiplier (SCAN_START, SCAN_WAIT); one result per round.
// Reset: control, counters and the rounds register clear at once; the node and
//   removal-mark memories are not cleared, each mark is zeroed as its node
//   is loaded, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module greedy_correlation_outlier_removal_core
    import gcor_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int MAX_ROUNDS = DEF_MAX_ROUNDS
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                node_valid,
    output logic                node_ready,
    input  node_item_t          node,
    output logic                result_valid,
    input  logic                result_ready,
    output result_item_t        result,
    input  logic                rounds_we,
    input  logic [ROUNDS_W-1:0] rounds_wdata
);

    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int NW    = CW + 2;
    localparam int SW    = CW + 18;
    localparam int QW    = CW + 33;
    localparam int SABW  = CW + 33;

    // node and removal-mark memories, registered read
    node_vals_t node_mem [MAX_NODES];
    logic       mark_mem [MAX_NODES];
    node_vals_t node_rd_reg;
    logic       mark_rd_reg;

    ctl_state_t state_reg, state_next;

    logic [ROUNDS_W-1:0] removal_rounds_reg;
    logic [ROUNDS_W-1:0] rounds_reg;
    logic [ROUNDS_W-1:0] round_reg;
    logic [ROUNDS_W-1:0] rounds_eff;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       walk_reg;
    logic [CW-1:0]       cnt_reg;

    logic rd_v_reg, ct_v_reg, ct_mark_reg;
    logic signed [17:0] ct_sa_reg, ct_sb_reg, ct_sa_next, ct_sb_next;
    logic [31:0]        ct_saa_reg, ct_sbb_reg, ct_saa_next, ct_sbb_next;
    logic signed [33:0] ct_sab_reg, ct_sab_next;

    logic signed [SW-1:0]   sa_reg, sb_reg, cand_sa_reg, cand_sb_reg;
    logic [QW-1:0]          saa_reg, sbb_reg, cand_saa_reg, cand_sbb_reg;
    logic signed [SABW-1:0] sab_reg, cand_sab_reg;
    logic [NW-1:0]          n_m1, n_val;

    logic                      found_reg;
    logic signed [SCORE_W-1:0] best_reg;
    logic [IDX_W-1:0]          best_idx_reg;

    result_item_t result_reg;
    logic         result_valid_reg;

    score_res_t score_res;

    logic load_fire, go_run, rd_en, round_init, sum_done, cand_load, score_start;
    logic emit_fire, scan_adv, scan_last, last_rnd, store_full, better;

    assign load_fire  = node_valid && node_ready;
    assign store_full = (count_reg == CW'(MAX_NODES));
    assign rounds_eff = (removal_rounds_reg > ROUNDS_W'(MAX_ROUNDS))
                        ? ROUNDS_W'(MAX_ROUNDS) : removal_rounds_reg;
    assign go_run     = load_fire && node.last_node && (rounds_eff != '0);
    assign scan_last  = ((walk_reg + CW'(1)) == count_reg);
    assign last_rnd   = ((round_reg + ROUNDS_W'(1)) == rounds_reg);
    assign better     = score_res.defined && (!found_reg || score_res.score > best_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (go_run) state_next = ST_SUM;
            ST_SUM:
                if (walk_reg == count_reg && !rd_v_reg && !ct_v_reg)
                    state_next = (cnt_reg == '0) ? ST_EMIT : ST_SCAN_RD;
            ST_SCAN_RD:
                state_next = ST_SCAN_PROD;
            ST_SCAN_PROD:
                state_next = ST_SCAN_SUB;
            ST_SCAN_SUB:
                if (ct_mark_reg)
                    state_next = scan_last ? ST_EMIT : ST_SCAN_RD;
                else
                    state_next = ST_SCAN_START;
            ST_SCAN_START:
                state_next = ST_SCAN_WAIT;
            ST_SCAN_WAIT:
                if (score_res.done)
                    state_next = scan_last ? ST_EMIT : ST_SCAN_RD;
            ST_EMIT:
                if (!result_valid_reg || result_ready)
                    state_next = last_rnd ? ST_LOAD : ST_SUM;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // control outputs
    always_comb
    begin
        node_ready  = (state_reg == ST_LOAD);
        rd_en       = ((state_reg == ST_SUM) && (walk_reg != count_reg)) ||
                      (state_reg == ST_SCAN_RD);
        emit_fire   = (state_reg == ST_EMIT) && (!result_valid_reg || result_ready);
        round_init  = go_run || (emit_fire && !last_rnd);
        sum_done    = (state_reg == ST_SUM) && (state_next != ST_SUM);
        cand_load   = (state_reg == ST_SCAN_SUB) && !ct_mark_reg;
        score_start = (state_reg == ST_SCAN_START);
        scan_adv    = ((state_reg == ST_SCAN_SUB) && ct_mark_reg) ||
                      ((state_reg == ST_SCAN_WAIT) && score_res.done);
    end

    // memories: node writes on load, mark zeroed on load and set on removal
    always_ff @(posedge clk)
    begin
        if (load_fire && !store_full)
        begin
            node_mem[count_reg[IDX_W-1:0]] <= '{a_first:  node.a_first,
                                                a_second: node.a_second,
                                                a_third:  node.a_third,
                                                b_first:  node.b_first,
                                                b_second: node.b_second,
                                                b_third:  node.b_third};
            mark_mem[count_reg[IDX_W-1:0]] <= 1'b0;
        end
        else if (emit_fire && found_reg)
            mark_mem[best_idx_reg] <= 1'b1;
        if (rd_en)
        begin
            node_rd_reg <= node_mem[walk_reg[IDX_W-1:0]];
            mark_rd_reg <= mark_mem[walk_reg[IDX_W-1:0]];
        end
    end

    // per-node contribution: three values, squares and cross products
    always_comb
    begin
        ct_sa_next  = 18'(node_rd_reg.a_first) + 18'(node_rd_reg.a_second)
                    + 18'(node_rd_reg.a_third);
        ct_sb_next  = 18'(node_rd_reg.b_first) + 18'(node_rd_reg.b_second)
                    + 18'(node_rd_reg.b_third);
        ct_saa_next = 32'(32'(node_rd_reg.a_first)  * 32'(node_rd_reg.a_first))
                    + 32'(32'(node_rd_reg.a_second) * 32'(node_rd_reg.a_second))
                    + 32'(32'(node_rd_reg.a_third)  * 32'(node_rd_reg.a_third));
        ct_sbb_next = 32'(32'(node_rd_reg.b_first)  * 32'(node_rd_reg.b_first))
                    + 32'(32'(node_rd_reg.b_second) * 32'(node_rd_reg.b_second))
                    + 32'(32'(node_rd_reg.b_third)  * 32'(node_rd_reg.b_third));
        ct_sab_next = 34'(32'(node_rd_reg.a_first)  * 32'(node_rd_reg.b_first))
                    + 34'(32'(node_rd_reg.a_second) * 32'(node_rd_reg.b_second))
                    + 34'(32'(node_rd_reg.a_third)  * 32'(node_rd_reg.b_third));
    end

    always_ff @(posedge clk)
    begin
        ct_sa_reg   <= ct_sa_next;
        ct_sb_reg   <= ct_sb_next;
        ct_saa_reg  <= ct_saa_next;
        ct_sbb_reg  <= ct_sbb_next;
        ct_sab_reg  <= ct_sab_next;
        ct_mark_reg <= mark_rd_reg;
    end

    // n = 3 * (included - 1) for the leave-one-out set
    assign n_m1  = NW'(cnt_reg) - NW'(1);
    assign n_val = (n_m1 << 1) + n_m1;

    // round totals and candidate sums
    always_ff @(posedge clk)
    begin
        if (round_init)
        begin
            sa_reg  <= '0;
            sb_reg  <= '0;
            saa_reg <= '0;
            sbb_reg <= '0;
            sab_reg <= '0;
        end
        else if (state_reg == ST_SUM && ct_v_reg && !ct_mark_reg)
        begin
            sa_reg  <= sa_reg  + SW'(ct_sa_reg);
            sb_reg  <= sb_reg  + SW'(ct_sb_reg);
            saa_reg <= saa_reg + QW'(ct_saa_reg);
            sbb_reg <= sbb_reg + QW'(ct_sbb_reg);
            sab_reg <= sab_reg + SABW'(ct_sab_reg);
        end
        if (cand_load)
        begin
            // drop this node from the totals
            cand_sa_reg  <= sa_reg  - SW'(ct_sa_reg);
            cand_sb_reg  <= sb_reg  - SW'(ct_sb_reg);
            cand_saa_reg <= saa_reg - QW'(ct_saa_reg);
            cand_sbb_reg <= sbb_reg - QW'(ct_sbb_reg);
            cand_sab_reg <= sab_reg - SABW'(ct_sab_reg);
        end
    end

    gcor_score #(.MAX_NODES(MAX_NODES)) u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .start (score_start),
        .n     (n_val),
        .sa    (cand_sa_reg),
        .sb    (cand_sb_reg),
        .saa   (cand_saa_reg),
        .sbb   (cand_sbb_reg),
        .sab   (cand_sab_reg),
        .res   (score_res)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_LOAD;
            removal_rounds_reg <= '0;
            rounds_reg         <= '0;
            round_reg          <= '0;
            count_reg          <= '0;
            walk_reg           <= '0;
            cnt_reg            <= '0;
            rd_v_reg           <= 1'b0;
            ct_v_reg           <= 1'b0;
            found_reg          <= 1'b0;
            best_reg           <= '0;
            best_idx_reg       <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= rd_en;
            ct_v_reg  <= rd_v_reg;

            if (rounds_we)
                removal_rounds_reg <= rounds_wdata;

            // load: advance the fill count; a zero-round set clears at once
            if (load_fire)
            begin
                if (node.last_node && rounds_eff == '0)
                    count_reg <= '0;
                else if (!store_full)
                    count_reg <= count_reg + CW'(1);
                if (go_run)
                begin
                    rounds_reg <= rounds_eff;
                    round_reg  <= '0;
                end
            end

            if (round_init)
            begin
                walk_reg     <= '0;
                cnt_reg      <= '0;
                found_reg    <= 1'b0;
                best_reg     <= {1'b1, {(SCORE_W-1){1'b0}}};
                best_idx_reg <= '0;
            end
            else
            begin
                if (state_reg == ST_SUM && rd_en)
                    walk_reg <= walk_reg + CW'(1);
                if (state_reg == ST_SUM && ct_v_reg && !ct_mark_reg)
                    cnt_reg <= cnt_reg + CW'(1);
                if (sum_done)
                    walk_reg <= '0;
                if (scan_adv)
                    walk_reg <= walk_reg + CW'(1);
                if (state_reg == ST_SCAN_WAIT && score_res.done && better)
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= score_res.score;
                    best_idx_reg <= walk_reg[IDX_W-1:0];
                end
            end

            // output register: hold until taken, then drop or refill
            if (emit_fire)
            begin
                result_valid_reg <= 1'b1;
                round_reg        <= round_reg + ROUNDS_W'(1);
                if (last_rnd)
                    count_reg <= '0;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            result_reg.removed_index <= INDEX_W'(best_idx_reg);
            result_reg.removal_valid <= found_reg;
            result_reg.best_score    <= best_reg;
            result_reg.last_round    <= last_rnd;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
